// File: rtl/modbus_rtu_reply_receiver_unit_defines.svh
// Assertion macros for the Modbus RTU reply receiver.
// No dependencies; taken in by mrr_frame_core, which checks its own logic.
`ifndef MODBUS_RTU_REPLY_RECEIVER_UNIT_DEFINES_SVH
`define MODBUS_RTU_REPLY_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MRR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRR_ASSERT_RST(lbl, prop, msg)
`define MRR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/mrr_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the reply receiver.
// No dependencies.
package mrr_pkg;

  localparam int FRAME_CAP_DEF = 8;
  localparam int HDR_BYTES     = 5;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FUNC_READ = 8'h03;

  localparam logic [7:0] TICK_MS_RST   = 8'd5;
  localparam logic [7:0] IDLE_LIM_RST  = 8'd3;
  localparam logic [7:0] SLAVE_RST     = 8'd1;
  localparam logic [7:0] MAX_BCNT_RST  = 8'd2;

  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_TICK_MS   = 2'd0,
    REG_IDLE_LIM  = 2'd1,
    REG_SLAVE     = 2'd2,
    REG_MAX_BCNT  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_READING  = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] tick_ms;
    logic [7:0] idle_limit_ms;
    logic [7:0] slave_address;
    logic [7:0] max_byte_count;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  frame_length;
    logic [15:0] reading;
    status_t     status;
  } result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/mrr_frame_core.sv
// Frame state of the reply receiver: header store, counters, idle timer, running CRC
// and reply decoding. Depends on mrr_pkg and the assertion macro header.
`include "modbus_rtu_reply_receiver_unit_defines.svh"

module mrr_frame_core #(
  parameter int FRAME_CAP = mrr_pkg::FRAME_CAP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic             mode,
  input  logic [7:0]       rx_byte,
  input  mrr_pkg::cfg_t    cfg,
  output mrr_pkg::result_t res
);

  localparam int CNT_W = $clog2(FRAME_CAP + 1);
  localparam int HDR   = mrr_pkg::HDR_BYTES;
  localparam int HIDX_W = $clog2(HDR);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(FRAME_CAP);

  logic [7:0]       hdr_r [HDR];
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0] seen_count_r, seen_count_nxt;
  logic [8:0]       idle_time_r, idle_time_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      reading_r, reading_nxt;
  logic             hdr_we;
  logic [8:0]       idle_sum;
  logic [7:0]       fb [HDR];
  mrr_pkg::status_t status;
  logic [3:0]       flen;

  always_comb begin
    for (int p = 0; p < HDR; p++) begin
      fb[p] = (CNT_W'(p) < byte_count_r) ? hdr_r[p] : 8'h00;
    end
  end

  assign idle_sum = idle_time_r + {1'b0, cfg.tick_ms};
  assign hdr_we   = acc && !mode && (byte_count_r < CNT_W'(HDR));

  always_comb begin
    byte_count_nxt = byte_count_r;
    seen_count_nxt = seen_count_r;
    idle_time_nxt  = idle_time_r;
    crc_nxt        = crc_r;
    reading_nxt    = reading_r;
    status         = mrr_pkg::ST_NONE;
    flen           = 4'd0;
    if (!mode) begin
      if (byte_count_r < CAP_C) begin
        byte_count_nxt = byte_count_r + CNT_W'(1);
        crc_nxt        = mrr_pkg::crc_step(crc_r, rx_byte);
      end else begin
        byte_count_nxt = '0;
        seen_count_nxt = '0;
        idle_time_nxt  = '0;
        crc_nxt        = mrr_pkg::CRC_INIT;
        status         = mrr_pkg::ST_OVERFLOW;
      end
    end else if (byte_count_r == '0) begin
      seen_count_nxt = '0;
      idle_time_nxt  = '0;
    end else if (seen_count_r != byte_count_r) begin
      seen_count_nxt = byte_count_r;
      idle_time_nxt  = '0;
    end else if (idle_sum >= {1'b0, cfg.idle_limit_ms}) begin
      flen           = 4'(byte_count_r);
      byte_count_nxt = '0;
      seen_count_nxt = '0;
      idle_time_nxt  = '0;
      crc_nxt        = mrr_pkg::CRC_INIT;
      if (byte_count_r < CNT_W'(2) || crc_r != 16'h0000) begin
        status = mrr_pkg::ST_CRC_ERR;
      end else if (fb[0] == cfg.slave_address && fb[1] == mrr_pkg::FUNC_READ &&
                   fb[2] <= cfg.max_byte_count) begin
        reading_nxt = {fb[3], fb[4]};
        status      = mrr_pkg::ST_READING;
      end else begin
        status = mrr_pkg::ST_IGNORED;
      end
    end else begin
      idle_time_nxt = idle_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      seen_count_r <= '0;
      idle_time_r  <= '0;
      crc_r        <= mrr_pkg::CRC_INIT;
      reading_r    <= '0;
    end else if (acc) begin
      byte_count_r <= byte_count_nxt;
      seen_count_r <= seen_count_nxt;
      idle_time_r  <= idle_time_nxt;
      crc_r        <= crc_nxt;
      reading_r    <= reading_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[byte_count_r[HIDX_W-1:0]] <= rx_byte;
    end
  end

  assign res.status       = status;
  assign res.reading      = reading_nxt;
  assign res.frame_length = flen;

  `MRR_ASSERT_RST(a_count_cap, byte_count_r <= CAP_C, "byte count beyond frame capacity")
  `MRR_ASSERT_RST(a_seen_le_count, seen_count_r <= byte_count_r, "seen count ahead of byte count")
  `MRR_ASSERT_RST(a_ovf_clears, (acc && !mode && byte_count_r == CAP_C) |=> byte_count_r == '0,
                  "overflow did not clear the frame")
  `MRR_ASSERT_RST(a_idle_narrow, idle_time_r[8] == 1'b0, "idle timer past idle limit range")

endmodule

// File: rtl/mrr_out_reg.sv
// Result register with valid flag for the reply receiver's output stream.
// Depends on mrr_pkg.
module mrr_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  mrr_pkg::result_t res,
  input  logic             out_tready,
  output logic             out_tvalid,
  output mrr_pkg::result_t res_q,
  output logic             can_load
);

  logic             valid_r, valid_nxt;
  mrr_pkg::result_t res_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign res_q      = res_r;

endmodule

// File: rtl/modbus_rtu_reply_receiver_unit.sv
// Top level of the Modbus RTU reply receiver: configuration registers, APB port,
// frame core and result register. Depends on mrr_pkg, mrr_frame_core, mrr_out_reg.
//
// Usage:
//   in_ stream: one transaction per received UART byte (in_tuser = 0, byte in
//   in_tdata) or per millisecond timer tick (in_tuser = 1, in_tdata unused).
//   out_ stream: exactly one transaction per input transaction, carrying the
//   status code, the latest held reading and the length of a frame that ended.
//   cfg_ APB port: tick_ms at 0x0, idle_limit_ms at 0x4, slave_address at 0x8,
//   max_byte_count at 0xC; write only while the block is idle.
// Timing: an input transaction is processed in the cycle it is accepted and
//   its result is valid on the next cycle; the block takes one transaction per
//   cycle while out_tready is high; the CRC byte step and header
//   decode sit between the state registers and the result register.
// Reset: counters clear, CRC goes to 0xFFFF, reading to 0, registers to defaults.
// Stall: while out_tready is low and a result waits, in_tready drops; nothing
//   is lost and the held result stays stable.
module modbus_rtu_reply_receiver_unit #(
  parameter int FRAME_CAP = mrr_pkg::FRAME_CAP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  input  logic                          in_tuser,   // [0] mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // [2:0] status, [18:3] reading,
                                                    // [22:19] frame_length, [23] zero
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mrr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  mrr_pkg::cfg_t     cfg_r;
  mrr_pkg::result_t  res, res_q;
  mrr_pkg::reg_idx_t ridx;
  logic              acc, can_load, cfg_we;

  assign cfg_pready = 1'b1;
  assign ridx       = mrr_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms        <= mrr_pkg::TICK_MS_RST;
      cfg_r.idle_limit_ms  <= mrr_pkg::IDLE_LIM_RST;
      cfg_r.slave_address  <= mrr_pkg::SLAVE_RST;
      cfg_r.max_byte_count <= mrr_pkg::MAX_BCNT_RST;
    end else if (cfg_we) begin
      unique case (ridx)
        mrr_pkg::REG_TICK_MS:  cfg_r.tick_ms        <= cfg_pwdata[7:0];
        mrr_pkg::REG_IDLE_LIM: cfg_r.idle_limit_ms  <= cfg_pwdata[7:0];
        mrr_pkg::REG_SLAVE:    cfg_r.slave_address  <= cfg_pwdata[7:0];
        mrr_pkg::REG_MAX_BCNT: cfg_r.max_byte_count <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      mrr_pkg::REG_TICK_MS:  cfg_prdata = {24'h0, cfg_r.tick_ms};
      mrr_pkg::REG_IDLE_LIM: cfg_prdata = {24'h0, cfg_r.idle_limit_ms};
      mrr_pkg::REG_SLAVE:    cfg_prdata = {24'h0, cfg_r.slave_address};
      mrr_pkg::REG_MAX_BCNT: cfg_prdata = {24'h0, cfg_r.max_byte_count};
      default:               cfg_prdata = 32'h0;
    endcase
  end

  assign in_tready = can_load;
  assign acc       = in_tvalid && can_load;

  mrr_frame_core #(
    .FRAME_CAP(FRAME_CAP)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .mode    (in_tuser),
    .rx_byte (in_tdata),
    .cfg     (cfg_r),
    .res     (res)
  );

  mrr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (acc),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_q      (res_q),
    .can_load   (can_load)
  );

  assign out_tdata = {1'b0, res_q.frame_length, res_q.reading, res_q.status};

endmodule
